// ===== rtl/tws_pkg.sv =====
// shared types and constants for the three-voice wavetable synth
// no dependencies; imported by tws_ctrl, tws_dp and three_voice_wavetable_synth
package tws_pkg;

  localparam int NUM_VOICES  = 3;
  localparam int PHASE_BITS  = 20;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int REG_COUNT   = 24;
  localparam int REG_AW      = $clog2(REG_COUNT);
  localparam int LEVEL_W     = 8;
  localparam int MIX_W       = 10;
  localparam int GAIN_W      = 8;
  localparam int SCALED_W    = MIX_W + GAIN_W;

  localparam logic [7:0] ENABLE_ADDR = 8'd24;

  localparam logic [1:0] FUNC_REG    = 2'd0;
  localparam logic [1:0] FUNC_TABLE  = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 8'd32;
  localparam logic [SCALED_W-1:0] SAT_MAX    = 18'd32767;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] addr;
    logic [3:0] data;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [7:0]         voice0_level;
    logic [7:0]         voice1_level;
    logic [7:0]         voice2_level;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic       take;
    logic       tick;
    logic       rd_en;
    logic [1:0] rd_voice;
    logic       scale;
    logic       load;
  } dp_cmd_t;

endpackage

// ===== rtl/tws_dp.sv =====
// datapath: sound registers, phase accumulators, waveform table memory, mixer and gain
// depends on tws_pkg
module tws_dp (
  input  logic              clk,
  input  logic              rst,
  input  tws_pkg::in_t      item,
  input  tws_pkg::dp_cmd_t  cmd,
  input  logic              gain_we,
  input  logic [7:0]        gain_wdata,
  output logic              enable,
  output tws_pkg::out_t     result
);
  import tws_pkg::*;

  logic [3:0]            vreg [REG_COUNT];
  logic [PHASE_BITS-1:0] phase [NUM_VOICES];
  logic [PHASE_BITS-1:0] freq [NUM_VOICES];
  logic [TABLE_AW-1:0]   idx [NUM_VOICES];
  logic [3:0]            vol [NUM_VOICES];
  logic [3:0]            wave_table [TABLE_DEPTH];
  logic [GAIN_W-1:0]     gain;
  logic [3:0]            rdata;
  logic                  rd_valid;
  logic [1:0]            rd_voice;
  logic [LEVEL_W-1:0]    level [NUM_VOICES];
  logic [MIX_W-1:0]      mix;
  logic [SCALED_W-1:0]   scaled;
  logic [TABLE_AW-1:0]   rd_idx;
  logic [3:0]            vol_sel;
  logic [LEVEL_W-1:0]    lvl;

  // voice 0 has a full 20-bit frequency, voices 1 and 2 are 16 bits shifted up a nibble
  assign freq[0] = {vreg[4], vreg[3], vreg[2], vreg[1], vreg[0]};
  assign freq[1] = {vreg[11], vreg[10], vreg[9], vreg[8], 4'h0};
  assign freq[2] = {vreg[19], vreg[18], vreg[17], vreg[16], 4'h0};

  for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
    assign idx[v] = {vreg[v*8+5][2:0], phase[v][PHASE_BITS-1 -: 5]};
    assign vol[v] = vreg[v*8+6];
  end

  always_comb begin
    case (cmd.rd_voice)
      2'd0:    rd_idx = idx[0];
      2'd1:    rd_idx = idx[1];
      default: rd_idx = idx[2];
    endcase
    case (rd_voice)
      2'd0:    vol_sel = vol[0];
      2'd1:    vol_sel = vol[1];
      default: vol_sel = vol[2];
    endcase
    lvl = {4'h0, rdata} * {4'h0, vol_sel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) vreg[i] <= 4'h0;
      for (int v = 0; v < NUM_VOICES; v++) phase[v] <= '0;
      enable   <= 1'b0;
      gain     <= GAIN_RESET;
      rd_valid <= 1'b0;
      rd_voice <= 2'd0;
    end else begin
      if (gain_we) gain <= gain_wdata;
      if (cmd.take && item.func == FUNC_REG) begin
        if (item.addr < 8'(REG_COUNT)) vreg[item.addr[REG_AW-1:0]] <= item.data;
        else if (item.addr == ENABLE_ADDR) enable <= item.data[0];
      end
      if (cmd.tick) begin
        for (int v = 0; v < NUM_VOICES; v++) phase[v] <= phase[v] + freq[v];
      end
      rd_valid <= cmd.rd_en;
      rd_voice <= cmd.rd_voice;
    end
  end

  // table memory and mixer payload
  always_ff @(posedge clk) begin
    if (cmd.take && item.func == FUNC_TABLE) wave_table[item.addr] <= item.data;
    if (cmd.rd_en) rdata <= wave_table[rd_idx];
    if (cmd.take) begin
      for (int v = 0; v < NUM_VOICES; v++) level[v] <= '0;
      mix    <= '0;
      scaled <= '0;
    end else begin
      if (rd_valid) begin
        case (rd_voice)
          2'd0:    level[0] <= lvl;
          2'd1:    level[1] <= lvl;
          default: level[2] <= lvl;
        endcase
        mix <= mix + MIX_W'(lvl);
      end
      if (cmd.scale) scaled <= SCALED_W'(mix) * SCALED_W'(gain);
    end
  end

  always_comb begin
    result.sample       = (scaled > SAT_MAX) ? 16'sh7fff : signed'(scaled[15:0]);
    result.voice0_level = level[0];
    result.voice1_level = level[1];
    result.voice2_level = level[2];
  end

endmodule

// ===== rtl/tws_ctrl.sv =====
// controller: sequences the two generator ticks, the three table reads and the gain step
// depends on tws_pkg
module tws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tws_pkg::in_t      item,
  input  logic              enable,
  input  logic              out_free,
  output logic              in_ready,
  output tws_pkg::dp_cmd_t  cmd
);
  import tws_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK0 = 3'd1;
  localparam logic [2:0] S_TICK1 = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] cnt, cnt_next;
  logic       take;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (take && item.func == FUNC_SAMPLE) state_next = enable ? S_TICK0 : S_DONE;
      end
      S_TICK0: state_next = S_TICK1;
      S_TICK1: begin
        state_next = S_READ;
        cnt_next   = 2'd0;
      end
      S_READ: begin
        if (cnt == 2'(NUM_VOICES - 1)) state_next = S_DRAIN;
        else cnt_next = cnt + 2'd1;
      end
      S_DRAIN: state_next = S_SCALE;
      S_SCALE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 2'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd.take     = take;
    cmd.tick     = (state == S_TICK0) || (state == S_TICK1);
    cmd.rd_en    = (state == S_READ);
    cmd.rd_voice = cnt;
    cmd.scale    = (state == S_SCALE);
    cmd.load     = (state == S_DONE) && out_free;
  end

  a_no_tick_during_read: assert property (@(posedge clk) disable iff (rst)
    !(cmd.tick && cmd.rd_en)) else $error("phase advance during table read");

  a_voice_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> cmd.rd_voice != 2'd3) else $error("table read for a missing voice");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> out_free) else $error("result loaded over a waiting one");

  a_scale_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.scale |=> state == S_DONE) else $error("gain step not followed by result");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (take && item.func == FUNC_SAMPLE) |=> !in_ready) else $error("new request taken mid-sample");

endmodule

// ===== rtl/three_voice_wavetable_synth.sv =====
// Three-voice wavetable sound generator.
// Request channel (in_valid/in_ready/in_item): func 0 writes a sound register,
// func 1 writes a waveform table nibble, func 2 asks for one sample, func 3 is dropped.
// Result channel (out_valid/out_ready/out_item): one result per sample request only.
// gain_we/gain_wdata write the output gain; the user must do so only while the block is idle (not enforced here).
// Register and table writes take effect at acceptance; in_ready stays high after them.
// A sample request with sound enabled runs two phase ticks, three table reads (one
// memory port, one voice per cycle), a drain state and a gain multiply, stepping
// through S_TICK0, S_TICK1, S_READ, S_DRAIN, S_SCALE and S_DONE; from S_DONE the result
// is loaded into the output register, and no new request is taken until the sample is
// through. With sound disabled the request goes straight to S_DONE with a zero result.
// The result sits in an output register; while the receiver stalls the block still
// takes register and table writes, and a following sample request is computed and
// then held until the output register frees.
// Reset (rst, synchronous) clears sound registers, enable, phases and the output
// valid, and sets the gain to 32. The waveform table is not cleared.
// depends on tws_pkg, tws_ctrl, tws_dp
module three_voice_wavetable_synth (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tws_pkg::in_t   in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output tws_pkg::out_t  out_item,
  input  logic           gain_we,
  input  logic [7:0]     gain_wdata
);
  import tws_pkg::*;

  dp_cmd_t cmd;
  out_t    result;
  logic    enable;
  logic    out_free;

  assign out_free = !out_valid || out_ready;

  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .item     (in_item),
    .enable   (enable),
    .out_free (out_free),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tws_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (in_item),
    .cmd        (cmd),
    .gain_we    (gain_we),
    .gain_wdata (gain_wdata),
    .enable     (enable),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_item <= result;
  end

endmodule
